### hdl/rhls_pkg.sv
// Shared types and constants for the RGB to HLS converter.
// Used by rhls_front, rhls_div_lane, rgb_to_hls_converter and tb_top; depends on nothing.
`timescale 1ns / 1ps

package rhls_pkg;

	// Field widths of the pixel and of the result
	localparam int COMP_W  = 8;
	localparam int HUE_W   = 13;
	localparam int LIGHT_W = 11;
	localparam int SAT_W   = 11;

	// Divider lane geometry: one quotient bit per stage
	localparam int NUM_W  = 22;
	localparam int DEN_W  = 10;
	localparam int QUO_W  = 13;
	localparam int WIDE_W = NUM_W + DEN_W;

	// Signed width of the raw hue numerator
	localparam int HNUM_W = 23;

	// Hue scale in 1/16 degree
	localparam int HUE_SECTOR     = 960;
	localparam int HUE_BASE_GREEN = 1920;
	localparam int HUE_BASE_BLUE  = 3840;
	localparam int HUE_FULL       = 5760;
	localparam int HUE_MAX        = 5759;

	// Lightness and saturation scale in 1/16 percent
	localparam int PCT_FULL     = 1600;
	localparam int PCT_TWICE    = 3200;
	localparam int COMP_SUM_MAX = 510;
	localparam int COMP_HALF    = 255;

	// Lightness divides by the constant 1020: multiply by ceil(2^32 / 1020)
	// and keep the bits above 2^32; exact for every numerator up to 2^22
	localparam int LIGHT_RECIP   = 4210753;
	localparam int LIGHT_RECIP_W = 23;
	localparam int LIGHT_SHIFT   = 32;
	localparam int LIGHT_PROD_W  = NUM_W + LIGHT_RECIP_W;

	// Front end depth, and accept-to-strobe latency in cycles
	localparam int FRONT_STAGES = 3;
	localparam int PIPE_LAT     = FRONT_STAGES + QUO_W + 1;

	// Which component holds the maximum
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sect_t;

	// One rounded division: quotient = floor(num / den)
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	// Beat handed from the front end to the two divider lanes and the
	// lightness path (numerator over the fixed divisor 1020)
	typedef struct packed {
		logic             vld;
		div_req_t         hue;
		div_req_t         sat;
		logic [NUM_W-1:0] light;
	} front_beat_t;

endpackage

### hdl/rhls_front.sv
// Front end of the RGB to HLS converter: max/min search, sector select and
// forming of the division operands over three register stages. Uses rhls_pkg.
`timescale 1ns / 1ps

module rhls_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [rhls_pkg::COMP_W-1:0]   red,
	input  logic [rhls_pkg::COMP_W-1:0]   green,
	input  logic [rhls_pkg::COMP_W-1:0]   blue,
	output rhls_pkg::front_beat_t         beat
);
	import rhls_pkg::*;

	// Stage 1 registers
	logic                     vld_s1;
	logic [COMP_W-1:0]        mx_s1;
	logic [COMP_W-1:0]        mn_s1;
	sect_t                    sect_s1;
	logic signed [COMP_W:0]   diff_s1;

	// Stage 2 registers
	logic                     vld_s2;
	logic [COMP_W-1:0]        delta_s2;
	logic [COMP_W:0]          sum_s2;
	logic signed [HNUM_W-1:0] hnum_s2;

	// Stage 3 registers
	logic                     vld_s3;
	div_req_t                 hue_s3;
	div_req_t                 sat_s3;
	logic [NUM_W-1:0]         light_s3;

	// Stage 1 logic
	logic [COMP_W-1:0]        mx_c;
	logic [COMP_W-1:0]        mn_c;
	sect_t                    sect_c;
	logic signed [COMP_W:0]   diff_c;

	// Stage 2 logic
	logic [COMP_W-1:0]        delta_c;
	logic [HNUM_W-1:0]        base_c;
	logic signed [HNUM_W-1:0] scaled_c;

	// Stage 3 logic
	logic                     grey_c;
	logic signed [HNUM_W-1:0] hfix_c;
	logic [COMP_W-1:0]        dsat_c;
	front_beat_t              beat_c;

	// Find max and min; ties go red, then green, then blue
	always_comb begin
		mx_c = red;
		mn_c = red;
		if (green > mx_c) mx_c = green;
		if (blue > mx_c)  mx_c = blue;
		if (green < mn_c) mn_c = green;
		if (blue < mn_c)  mn_c = blue;
		if (red == mx_c) begin
			sect_c = SECT_RED;
			diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (green == mx_c) begin
			sect_c = SECT_GREEN;
			diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sect_c = SECT_BLUE;
			diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
		end
	end

	// Raw hue numerator: base * delta + 960 * diff
	always_comb begin
		delta_c = mx_s1 - mn_s1;
		case (sect_s1)
			SECT_GREEN: base_c = HNUM_W'(delta_c) * HNUM_W'(HUE_BASE_GREEN);
			SECT_BLUE:  base_c = HNUM_W'(delta_c) * HNUM_W'(HUE_BASE_BLUE);
			default:    base_c = '0;
		endcase
		scaled_c = HNUM_W'(diff_s1) * HNUM_W'(HUE_SECTOR);
	end

	// Wrap negative hue, pick the saturation divisor and build the operands
	always_comb begin
		grey_c = (delta_s2 == '0);
		hfix_c = hnum_s2;
		if (hnum_s2 < 0) begin
			hfix_c = hnum_s2 + $signed(HNUM_W'(delta_s2) * HNUM_W'(HUE_FULL));
		end
		if (sum_s2 < (COMP_W + 1)'(COMP_HALF)) begin
			dsat_c = sum_s2[COMP_W-1:0];
		end else begin
			dsat_c = COMP_W'((COMP_W + 1)'(COMP_SUM_MAX) - sum_s2);
		end

		beat_c.vld   = vld_s2;
		beat_c.light = NUM_W'(sum_s2) * NUM_W'(PCT_TWICE) + NUM_W'(COMP_SUM_MAX);
		if (grey_c) begin
			beat_c.hue.num = '0;
			beat_c.hue.den = DEN_W'(1);
			beat_c.sat.num = '0;
			beat_c.sat.den = DEN_W'(1);
		end else begin
			beat_c.hue.num = {hfix_c[NUM_W-2:0], 1'b0} + NUM_W'(delta_s2);
			beat_c.hue.den = DEN_W'({delta_s2, 1'b0});
			beat_c.sat.num = NUM_W'(delta_s2) * NUM_W'(PCT_TWICE) + NUM_W'(dsat_c);
			beat_c.sat.den = DEN_W'({dsat_c, 1'b0});
		end
	end

	// Valid bits: clear on reset, advance every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= beat_c.vld;
		end
	end

	// Payload: advance every cycle
	always_ff @(posedge clk) begin
		mx_s1    <= mx_c;
		mn_s1    <= mn_c;
		sect_s1  <= sect_c;
		diff_s1  <= diff_c;
		delta_s2 <= delta_c;
		sum_s2   <= (COMP_W + 1)'(mx_s1) + (COMP_W + 1)'(mn_s1);
		hnum_s2  <= $signed(base_c) + scaled_c;
		hue_s3   <= beat_c.hue;
		sat_s3   <= beat_c.sat;
		light_s3 <= beat_c.light;
	end

	assign beat = {vld_s3, hue_s3, sat_s3, light_s3};

endmodule

### hdl/rhls_div_lane.sv
// Pipelined restoring divider lane, one quotient bit per stage.
// Operand and quotient widths come from rhls_pkg.
`timescale 1ns / 1ps

module rhls_div_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  rhls_pkg::div_req_t          req,
	output logic                        out_vld,
	output logic [rhls_pkg::QUO_W-1:0]  quo
);
	import rhls_pkg::*;

	// Stage registers
	logic             vld_s [QUO_W];
	logic [NUM_W-1:0] rem_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];

	// Per-stage inputs and trial subtraction
	logic             vld_c   [QUO_W];
	logic [NUM_W-1:0] rem_c   [QUO_W];
	logic [DEN_W-1:0] den_c   [QUO_W];
	logic [QUO_W-1:0] quo_c   [QUO_W];
	logic [WIDE_W-1:0] trial_c [QUO_W];
	logic             fit_c   [QUO_W];

	// Route each stage's input from the previous stage
	always_comb begin
		vld_c[0] = in_vld;
		rem_c[0] = req.num;
		den_c[0] = req.den;
		quo_c[0] = '0;
		for (int i = 1; i < QUO_W; i++) begin
			vld_c[i] = vld_s[i-1];
			rem_c[i] = rem_s[i-1];
			den_c[i] = den_s[i-1];
			quo_c[i] = quo_s[i-1];
		end
	end

	// Compare the remainder against the shifted divisor, MSB first
	always_comb begin
		for (int i = 0; i < QUO_W; i++) begin
			trial_c[i] = WIDE_W'(den_c[i]) << (QUO_W - 1 - i);
			fit_c[i]   = WIDE_W'(rem_c[i]) >= trial_c[i];
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUO_W; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			for (int i = 0; i < QUO_W; i++) begin
				vld_s[i] <= vld_c[i];
			end
		end
	end

	// Subtract where it fits and set the quotient bit
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUO_W; i++) begin
			rem_s[i] <= fit_c[i] ? (rem_c[i] - trial_c[i][NUM_W-1:0]) : rem_c[i];
			den_s[i] <= den_c[i];
			quo_s[i] <= quo_c[i] | (QUO_W'(fit_c[i]) << (QUO_W - 1 - i));
		end
	end

	assign out_vld = vld_s[QUO_W-1];
	assign quo     = quo_s[QUO_W-1];

	// The final remainder must be below the divisor, else the quotient overflowed
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QUO_W-1] |-> (WIDE_W'(rem_s[QUO_W-1]) < WIDE_W'(den_s[QUO_W-1])))
		else $error("divider lane: final remainder not below divisor");

endmodule

### hdl/rgb_to_hls_converter.sv
// RGB to HLS converter top level: front end, two divider lanes, lightness path
// and output register. Depends on rhls_pkg, rhls_front and rhls_div_lane.
`timescale 1ns / 1ps

// Usage
//   Input: drive red, green, blue and raise start; a pixel beat is taken at
//   every rising edge with start high and busy low. busy is held low, so
//   one pixel can enter on every clock cycle.
//   Output: done is high for exactly one cycle with hue, lightness and
//   saturation; the beat is taken at the edge that ends that cycle.
//   Pipeline from the accepting edge to the edge that takes the result:
//   three front-end stages, thirteen divider stages (one quotient
//   bit each; lightness uses a constant multiply and a matching delay)
//   and the output register. Throughput: one pixel per cycle.
//   Hue is in 1/16 degree (0..5759); lightness and saturation are in
//   1/16 percent (0..1600); grey pixels give zero hue and saturation.
//   Reset (arst_n low) clears every valid bit at once, so no result comes
//   out for beats in flight. The receiver cannot stall: the pipeline never
//   holds, and results appear in the order the pixels were taken.

module rgb_to_hls_converter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rhls_pkg::COMP_W-1:0]   red,
	input  logic [rhls_pkg::COMP_W-1:0]   green,
	input  logic [rhls_pkg::COMP_W-1:0]   blue,
	output logic                          done,
	output logic [rhls_pkg::HUE_W-1:0]    hue,
	output logic [rhls_pkg::LIGHT_W-1:0]  lightness,
	output logic [rhls_pkg::SAT_W-1:0]    saturation
);
	import rhls_pkg::*;

	front_beat_t             beat;
	logic                    hue_vld;
	logic                    sat_vld;
	logic [QUO_W-1:0]        hue_quo;
	logic [QUO_W-1:0]        sat_quo;

	logic [LIGHT_PROD_W-1:0] light_prod_c;
	logic [LIGHT_W-1:0]      light_c;
	logic [LIGHT_W-1:0]      light_s [QUO_W];

	logic                    done_q;
	logic [HUE_W-1:0]        hue_q;
	logic [LIGHT_W-1:0]      light_q;
	logic [SAT_W-1:0]        sat_q;

	// Never stall the input
	assign busy = 1'b0;

	rhls_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start && !busy),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.beat   (beat)
	);

	rhls_div_lane u_hue_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (beat.vld),
		.req     (beat.hue),
		.out_vld (hue_vld),
		.quo     (hue_quo)
	);

	rhls_div_lane u_sat_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (beat.vld),
		.req     (beat.sat),
		.out_vld (sat_vld),
		.quo     (sat_quo)
	);

	// Lightness: divide by 1020 with a reciprocal multiply
	assign light_prod_c = LIGHT_PROD_W'(beat.light) * LIGHT_PROD_W'(LIGHT_RECIP);
	assign light_c      = light_prod_c[LIGHT_SHIFT +: LIGHT_W];

	// Delay lightness to line up with the divider lanes
	always_ff @(posedge clk) begin
		light_s[0] <= light_c;
		for (int i = 1; i < QUO_W; i++) begin
			light_s[i] <= light_s[i-1];
		end
	end

	// Strobe register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= hue_vld;
		end
	end

	// Clamp and hold the result
	always_ff @(posedge clk) begin
		hue_q   <= (hue_quo > QUO_W'(HUE_MAX)) ? HUE_W'(HUE_MAX) : hue_quo[HUE_W-1:0];
		sat_q   <= (sat_quo > QUO_W'(PCT_FULL)) ? SAT_W'(PCT_FULL) : sat_quo[SAT_W-1:0];
		light_q <= light_s[QUO_W-1];
	end

	assign done       = done_q;
	assign hue        = hue_q;
	assign lightness  = light_q;
	assign saturation = sat_q;

	// The two lanes run in lockstep
	assert property (@(posedge clk) disable iff (!arst_n)
		hue_vld == sat_vld)
		else $error("divider lanes out of step");

	// Every result comes from a beat taken a fixed latency earlier
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without matching input beat");

	// Lightness never needs clamping
	assert property (@(posedge clk) disable iff (!arst_n)
		hue_vld |-> (light_s[QUO_W-1] <= LIGHT_W'(PCT_FULL)))
		else $error("lightness out of range");

endmodule

### tb/tb_top.sv
// Self-checking bench for the RGB to HLS converter: corner pixels and random beats.
// Depends on rhls_pkg and rgb_to_hls_converter; a scoreboard class holds the predicted results.
`timescale 1ns / 1ps

module tb_top;
	import rhls_pkg::*;

	typedef struct packed {
		logic [HUE_W-1:0]   hue;
		logic [LIGHT_W-1:0] lightness;
		logic [SAT_W-1:0]   saturation;
	} hls_t;

	// Predicted results, oldest first, checked against each done strobe
	class hls_scoreboard;
		hls_t pending_hls[$];
		int   errors;

		function new();
			errors = 0;
		endfunction

		// Round to nearest, exact half up
		function automatic int round_div(int num, int den);
			return (2 * num + den) / (2 * den);
		endfunction

		function automatic hls_t predict_hls(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			int    mx, mn, delta, sum, den, num, val;
			sect_t sect;
			hls_t  res;
			mx = int'(r);
			mn = int'(r);
			if (g > mx) mx = int'(g);
			if (b > mx) mx = int'(b);
			if (g < mn) mn = int'(g);
			if (b < mn) mn = int'(b);
			delta = mx - mn;
			sum = mx + mn;
			res = '0;
			res.lightness = LIGHT_W'(round_div(sum * PCT_FULL, COMP_SUM_MAX));
			// Grey pixels keep zero hue and saturation
			if (delta != 0) begin
				den = (sum < COMP_HALF) ? sum : COMP_SUM_MAX - sum;
				val = round_div(delta * PCT_FULL, den);
				if (val > PCT_FULL) val = PCT_FULL;
				res.saturation = SAT_W'(val);
				// Ties go to red, then green
				if (r == mx) sect = SECT_RED;
				else if (g == mx) sect = SECT_GREEN;
				else sect = SECT_BLUE;
				case (sect)
					SECT_RED:   num = HUE_SECTOR * (int'(g) - int'(b));
					SECT_GREEN: num = HUE_BASE_GREEN * delta + HUE_SECTOR * (int'(b) - int'(r));
					default:    num = HUE_BASE_BLUE * delta + HUE_SECTOR * (int'(r) - int'(g));
				endcase
				// Wrap a negative angle into the circle
				if (num < 0) num += HUE_FULL * delta;
				if (num < 0) num = 0;
				val = round_div(num, delta);
				if (val > HUE_MAX) val = HUE_MAX;
				res.hue = HUE_W'(val);
			end
			return res;
		endfunction

		function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			pending_hls.push_back(predict_hls(r, g, b));
		endfunction

		function void check_result(logic [HUE_W-1:0] h, logic [LIGHT_W-1:0] l,
				logic [SAT_W-1:0] s);
			hls_t want;
			if (pending_hls.size() == 0) begin
				$display("%0t unexpected result: hue %0d lightness %0d saturation %0d",
					$time, h, l, s);
				errors++;
				return;
			end
			want = pending_hls.pop_front();
			if (h !== want.hue) begin
				$display("%0t hue mismatch: expected %0d, actual %0d", $time, want.hue, h);
				errors++;
			end
			if (l !== want.lightness) begin
				$display("%0t lightness mismatch: expected %0d, actual %0d",
					$time, want.lightness, l);
				errors++;
			end
			if (s !== want.saturation) begin
				$display("%0t saturation mismatch: expected %0d, actual %0d",
					$time, want.saturation, s);
				errors++;
			end
		endfunction
	endclass

	localparam int PIXEL_COUNT = 1950;
	localparam int CALM_TAIL   = 300;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [COMP_W-1:0]  red = '0;
	logic [COMP_W-1:0]  green = '0;
	logic [COMP_W-1:0]  blue = '0;
	logic               busy;
	logic               done;
	logic [HUE_W-1:0]   hue;
	logic [LIGHT_W-1:0] lightness;
	logic [SAT_W-1:0]   saturation;

	hls_scoreboard sb = new();

	rgb_to_hls_converter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.done       (done),
		.hue        (hue),
		.lightness  (lightness),
		.saturation (saturation)
	);

	always #1 clk = ~clk;

	// Note accepted pixel beats and check every result beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.note_pixel(red, green, blue);
			if (done) sb.check_result(hue, lightness, saturation);
		end
	end

	// Offer one pixel and hold it until the block takes it
	task automatic drive_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		start <= 1'b1;
		red   <= r;
		green <= g;
		blue  <= b;
		do @(posedge clk); while (busy);
	endtask

	// Drop start for a burst of cycles
	task automatic idle_cycles(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Drop start until every predicted result has come back
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_hls.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [23:0] corner_px[$] = '{
			24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFE0000, 24'hC83700,
			24'h010000, 24'hFFFEFE, 24'h000101, 24'hFFFFFE, 24'h010001, 24'h7F8000,
			24'h80007F, 24'h01FF00, 24'h0001FF, 24'hFF8040, 24'h3A7FC0, 24'hAA55AA
		};
		logic [7:0] r, g, b;
		int         kind;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner pixels: extremes, grey, ties, wrap and the sum boundary
		foreach (corner_px[i])
			drive_pixel(corner_px[i][23:16], corner_px[i][15:8], corner_px[i][7:0]);
		wait_drained();

		for (int i = 0; i < PIXEL_COUNT; i++) begin
			kind = $urandom_range(99);
			r = 8'($urandom_range(255));
			g = 8'($urandom_range(255));
			b = 8'($urandom_range(255));
			if (kind < 12) begin
				// Grey
				g = r;
				b = r;
			end else if (kind < 27) begin
				// Tie for the maximum or minimum between two components
				case ($urandom_range(2))
					0: g = r;
					1: b = g;
					default: b = r;
				endcase
			end else if (kind < 37) begin
				// Components near the rails and the middle
				r = $urandom_range(1) ? {7'h7F, 1'(r[0])} : {7'h00, 1'(r[0])};
				g = $urandom_range(1) ? 8'd127 + g[0] : g;
				b = $urandom_range(1) ? {7'h7F, 1'(b[0])} : {7'h00, 1'(b[0])};
			end
			drive_pixel(r, g, b);
			if (i == PIXEL_COUNT / 2)
				wait_drained();
			else if (i < PIXEL_COUNT - CALM_TAIL && $urandom_range(5) == 0)
				idle_cycles($urandom_range(1, 18));
		end

		// Drain and let the pipeline settle to catch stray strobes
		wait_drained();
		repeat (PIPE_LAT + 8) @(posedge clk);
		if (sb.errors == 0 && sb.pending_hls.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.errors, sb.pending_hls.size());
			$display("Regression FAIL");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#1000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
